### src/wpf_pkg.sv
// Package for the waypoint path follower: constants, types and the CORDIC arctangent table.
// Has no dependencies. It is used by waypoint_path_follower.
`default_nettype none
package wpf_pkg;
    localparam int MaxWaypoints = 64;
    localparam int IdxW         = $clog2(MaxWaypoints);
    localparam int CntW         = IdxW + 1;
    localparam int CordicSteps  = 16;
    localparam int StepW        = $clog2(CordicSteps + 1);

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_TICK = 2'd1;
    localparam logic [1:0] MODE_STOP = 2'd2;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MOVING = 3'd1;
    localparam logic [2:0] ST_DONE   = 3'd2;
    localparam logic [2:0] ST_STORED = 3'd3;
    localparam logic [2:0] ST_FULL   = 3'd4;

    localparam logic signed [16:0] HEADING_OFFSET = 17'sd11520;
    localparam logic signed [16:0] HEADING_MIN    = -17'sd34560;
    localparam logic signed [16:0] HEADING_MAX    = 17'sd11520;
    localparam logic signed [31:0] ANG_180        = 32'sd11796480;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_DIFF,
        S_SQ,
        S_CMP,
        S_STEP,
        S_SQRT,
        S_DIV,
        S_MOVE,
        S_CORDIC,
        S_HEAD,
        S_OUT
    } state_t;

    function automatic logic [21:0] atan_entry(input logic [4:0] i);
        logic [21:0] v;
        begin
            case (i)
                5'd0:    v = 22'd2949120;
                5'd1:    v = 22'd1740967;
                5'd2:    v = 22'd919879;
                5'd3:    v = 22'd466945;
                5'd4:    v = 22'd234379;
                5'd5:    v = 22'd117304;
                5'd6:    v = 22'd58666;
                5'd7:    v = 22'd29335;
                5'd8:    v = 22'd14668;
                5'd9:    v = 22'd7334;
                5'd10:   v = 22'd3667;
                5'd11:   v = 22'd1833;
                5'd12:   v = 22'd917;
                5'd13:   v = 22'd458;
                5'd14:   v = 22'd229;
                5'd15:   v = 22'd115;
                5'd16:   v = 22'd57;
                5'd17:   v = 22'd29;
                5'd18:   v = 22'd14;
                5'd19:   v = 22'd7;
                5'd20:   v = 22'd4;
                5'd21:   v = 22'd2;
                5'd22:   v = 22'd1;
                default: v = 22'd0;
            endcase
            return v;
        end
    endfunction
endpackage
`default_nettype wire

### src/wpf_ram.sv
// Generic dual-port RAM: one write and one read per cycle, with the read data registered.
// Has no dependencies.
`default_nettype none
module wpf_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### src/waypoint_path_follower.sv
// Waypoint path follower, top level: the sequencer, its shared datapath and the waypoint RAM.
// Depends on wpf_pkg and wpf_ram.
//
// Load and stop beats go from acceptance straight to the result. A tick beat runs a sequencer
// over one shared datapath. The square root takes 17 steps, each of the two divisions takes
// 32 steps, and the CORDIC takes at most 16 steps. A tick that moves part of the way runs the
// root, both divisions and the CORDIC; a step that reaches the target skips the root and
// divisions. A target within the stop distance advances the index or, if last, ends the path.
// A beat waits until the result is taken. The single RAM read port is read once per target.
`default_nettype none
module waypoint_path_follower (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         mode,
    input  wire logic signed [15:0] waypoint_x,
    input  wire logic signed [15:0] waypoint_y,
    input  wire logic               new_path,
    input  wire logic [15:0]        tick_time,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      pos_x,
    output logic signed [15:0]      pos_y,
    output logic signed [16:0]      heading,
    output logic [2:0]              status,
    output logic [6:0]              target_index,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [15:0]        cfg_data
);
    import wpf_pkg::*;

    state_t state_reg, state_next;

    logic [15:0]        speed_reg;
    logic [7:0]         stopd_reg;
    logic signed [15:0] px_reg, py_reg;
    logic signed [16:0] head_reg;
    logic [CntW-1:0]    count_reg, index_reg;
    logic               active_reg;
    logic [2:0]         status_reg;
    logic [15:0]        dt_reg;
    logic               second_reg;

    logic signed [15:0] tx_reg, ty_reg;
    logic signed [16:0] dx_reg, dy_reg;
    logic [33:0]        d2_reg;
    logic [31:0]        step_reg;
    logic [33:0]        rem_reg;
    logic [16:0]        root_reg;
    logic [5:0]         cnt_reg;
    logic               axis_reg;
    logic [47:0]        num_reg;
    logic [31:0]        quo_reg;
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [31:0] cz_reg;

    // waypoint RAM
    logic            ram_we;
    logic [IdxW-1:0] ram_waddr, ram_raddr;
    logic [31:0]     ram_rdata;

    wpf_ram #(.Width(32), .Depth(MaxWaypoints)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({waypoint_y, waypoint_x}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic in_fire;
    logic [CntW-1:0] load_base;
    assign in_fire   = in_valid && in_ready;
    assign load_base = new_path ? '0 : count_reg;
    assign ram_we    = in_fire && (mode == MODE_LOAD) && (load_base < CntW'(MaxWaypoints));
    assign ram_waddr = load_base[IdxW-1:0];
    assign ram_raddr = index_reg[IdxW-1:0];
    assign cfg_ready = (state_reg == S_IDLE);

    // shared sub-results
    logic [33:0] sq_a;
    logic [33:0] sqrt_trial;
    logic [18:0] root_try;
    logic        sqrt_fit;
    logic [33:0] sqrt_rem;
    logic [16:0] sqrt_root;
    logic signed [33:0] shx, shy;
    logic [16:0] absd;
    logic [31:0] mag;
    logic signed [31:0] zr;

    always_comb
    begin
        sq_a       = 34'(dx_reg * dx_reg) + 34'(dy_reg * dy_reg);
        // digit-by-digit root: trial is 4*root + 1 against the next two radicand bits
        root_try   = {root_reg, 2'b01};
        sqrt_trial = {rem_reg[31:0], d2_reg[33:32]};
        sqrt_fit   = (sqrt_trial >= 34'(root_try));
        sqrt_rem   = sqrt_fit ? sqrt_trial - 34'(root_try) : sqrt_trial;
        sqrt_root  = {root_reg[15:0], sqrt_fit};
        shx        = cx_reg >>> cnt_reg[4:0];
        shy        = cy_reg >>> cnt_reg[4:0];
        absd       = axis_reg ? (dy_reg[16] ? 17'(-dy_reg) : 17'(dy_reg))
                              : (dx_reg[16] ? 17'(-dx_reg) : 17'(dx_reg));
        mag        = quo_reg;
        zr         = (cz_reg + 32'sd256) >>> 9;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (mode == MODE_TICK && active_reg && index_reg < count_reg)
                        state_next = S_READ;
                    else
                        state_next = S_OUT;
                end
            end
            S_READ:   state_next = S_DIFF;
            S_DIFF:   state_next = S_SQ;
            S_SQ:     state_next = S_CMP;
            S_CMP:
            begin
                if (!second_reg && d2_reg < 34'(stopd_reg * stopd_reg))
                begin
                    if (index_reg + 1'b1 >= count_reg)
                        state_next = S_OUT;
                    else
                        state_next = S_READ;
                end
                else
                    state_next = S_STEP;
            end
            S_STEP:   state_next = (34'(step_reg[16:0] * step_reg[16:0]) >= d2_reg
                                   || step_reg[31:17] != '0) ? S_CORDIC : S_SQRT;
            S_SQRT:   state_next = (cnt_reg == 6'd16) ? S_DIV : S_SQRT;
            S_DIV:    state_next = (cnt_reg == 6'd32) ? S_MOVE : S_DIV;
            S_MOVE:   state_next = axis_reg ? S_CORDIC : S_DIV;
            S_CORDIC: state_next = (cx_reg == '0 && cy_reg == '0) ? S_HEAD
                                 : ((cnt_reg == 6'(CordicSteps)) ? S_HEAD : S_CORDIC);
            S_HEAD:   state_next = S_OUT;
            S_OUT:    state_next = out_ready ? S_IDLE : S_OUT;
            default:  state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready     = (state_reg == S_IDLE) && !cfg_valid;
        out_valid    = (state_reg == S_OUT);
        pos_x        = px_reg;
        pos_y        = py_reg;
        heading      = head_reg;
        status       = status_reg;
        target_index = 7'(index_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            speed_reg  <= 16'd512;
            stopd_reg  <= 8'd3;
            px_reg     <= '0;
            py_reg     <= '0;
            head_reg   <= '0;
            count_reg  <= '0;
            index_reg  <= '0;
            active_reg <= 1'b0;
            status_reg <= ST_IDLE;
            second_reg <= 1'b0;
            cnt_reg    <= '0;
            axis_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index) stopd_reg <= cfg_data[7:0];
                else           speed_reg <= cfg_data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    second_reg <= 1'b0;
                    if (in_fire)
                    begin
                        dt_reg <= tick_time;
                        case (mode)
                            MODE_LOAD:
                            begin
                                if (new_path)
                                    index_reg <= '0;
                                if (load_base < CntW'(MaxWaypoints))
                                begin
                                    count_reg  <= load_base + 1'b1;
                                    active_reg <= 1'b1;
                                    status_reg <= ST_STORED;
                                end
                                else
                                begin
                                    count_reg  <= load_base;
                                    status_reg <= ST_FULL;
                                    if (new_path)
                                        active_reg <= 1'b0;
                                end
                            end
                            MODE_STOP:
                            begin
                                count_reg  <= '0;
                                index_reg  <= '0;
                                active_reg <= 1'b0;
                                status_reg <= ST_IDLE;
                            end
                            default: status_reg <= ST_IDLE;
                        endcase
                    end
                end
                S_READ: ;
                S_DIFF:
                begin
                    tx_reg <= ram_rdata[15:0];
                    ty_reg <= ram_rdata[31:16];
                    dx_reg <= 17'(signed'(ram_rdata[15:0])) - 17'(px_reg);
                    dy_reg <= 17'(signed'(ram_rdata[31:16])) - 17'(py_reg);
                end
                S_SQ:
                begin
                    d2_reg   <= sq_a;
                    step_reg <= 32'(speed_reg * dt_reg) >> 16;
                end
                S_CMP:
                begin
                    if (!second_reg && d2_reg < 34'(stopd_reg * stopd_reg))
                    begin
                        second_reg <= 1'b1;
                        if (index_reg + 1'b1 >= count_reg)
                        begin
                            px_reg     <= tx_reg;
                            py_reg     <= ty_reg;
                            count_reg  <= '0;
                            index_reg  <= '0;
                            active_reg <= 1'b0;
                            status_reg <= ST_DONE;
                        end
                        else
                            index_reg <= index_reg + 1'b1;
                    end
                    rem_reg  <= '0;
                    root_reg <= '0;
                    cnt_reg  <= '0;
                end
                S_STEP:
                begin
                    status_reg <= ST_MOVING;
                    if (34'(step_reg[16:0] * step_reg[16:0]) >= d2_reg
                        || step_reg[31:17] != '0)
                    begin
                        px_reg <= tx_reg;
                        py_reg <= ty_reg;
                    end
                    cx_reg   <= dx_reg[16] ? -(34'(dx_reg) <<< 8) : (34'(dx_reg) <<< 8);
                    cy_reg   <= dx_reg[16] ? -(34'(dy_reg) <<< 8) : (34'(dy_reg) <<< 8);
                    cz_reg   <= dx_reg[16] ? (dy_reg[16] ? -ANG_180 : ANG_180) : '0;
                    cnt_reg  <= '0;
                    axis_reg <= 1'b0;
                end
                S_SQRT:
                begin
                    // one result bit per cycle, two radicand bits
                    d2_reg <= {d2_reg[31:0], 2'b00};
                    if (cnt_reg == 6'd16)
                    begin
                        cnt_reg  <= '0;
                        num_reg  <= 48'(step_reg * absd);
                        quo_reg  <= '0;
                        rem_reg  <= '0;
                        root_reg <= (sqrt_root == '0) ? 17'd1 : sqrt_root;
                    end
                    else
                    begin
                        cnt_reg  <= cnt_reg + 1'b1;
                        rem_reg  <= sqrt_rem;
                        root_reg <= sqrt_root;
                    end
                end
                S_DIV:
                begin
                    // restoring division, one quotient bit per cycle
                    if (cnt_reg != 6'd32)
                    begin
                        if ({rem_reg[32:0], num_reg[31]} >= 34'(root_reg))
                        begin
                            rem_reg <= {rem_reg[32:0], num_reg[31]} - 34'(root_reg);
                            quo_reg <= {quo_reg[30:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= {rem_reg[32:0], num_reg[31]};
                            quo_reg <= {quo_reg[30:0], 1'b0};
                        end
                        num_reg <= {num_reg[46:0], 1'b0};
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_MOVE:
                begin
                    if (!axis_reg)
                        px_reg <= dx_reg[16] ? px_reg - 16'(mag) : px_reg + 16'(mag);
                    else
                        py_reg <= dy_reg[16] ? py_reg - 16'(mag) : py_reg + 16'(mag);
                    axis_reg <= 1'b1;
                    cnt_reg  <= '0;
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    num_reg  <= dy_reg[16] ? 48'(step_reg * 17'(-dy_reg))
                                           : 48'(step_reg * 17'(dy_reg));
                    if (axis_reg)
                    begin
                        cx_reg  <= dx_reg[16] ? -(34'(dx_reg) <<< 8) : (34'(dx_reg) <<< 8);
                        cy_reg  <= dx_reg[16] ? -(34'(dy_reg) <<< 8) : (34'(dy_reg) <<< 8);
                        cz_reg  <= dx_reg[16] ? (dy_reg[16] ? -ANG_180 : ANG_180) : '0;
                    end
                end
                S_CORDIC:
                begin
                    if (cx_reg == '0 && cy_reg == '0)
                        cz_reg <= '0;
                    else if (cnt_reg != 6'(CordicSteps))
                    begin
                        if (cy_reg > 0)
                        begin
                            cx_reg <= cx_reg + shy;
                            cy_reg <= cy_reg - shx;
                            cz_reg <= cz_reg + 32'(atan_entry(cnt_reg[4:0]));
                        end
                        else
                        begin
                            cx_reg <= cx_reg - shy;
                            cy_reg <= cy_reg + shx;
                            cz_reg <= cz_reg - 32'(atan_entry(cnt_reg[4:0]));
                        end
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_HEAD:
                begin
                    if (dx_reg == '0 && dy_reg == '0)
                        head_reg <= -HEADING_OFFSET;
                    else if (zr - 32'(HEADING_OFFSET) < 32'(HEADING_MIN))
                        head_reg <= HEADING_MIN;
                    else if (zr - 32'(HEADING_OFFSET) > 32'(HEADING_MAX))
                        head_reg <= HEADING_MAX;
                    else
                        head_reg <= 17'(zr - 32'(HEADING_OFFSET));
                end
                S_OUT: ;
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire
